[design/sem_pkg.sv]
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants, types and helpers of the scharr edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // configuration port
  localparam int CFG_W       = 12;
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);
  localparam int IMAGE_WIDTH_RESET  = 640;
  localparam int IMAGE_HEIGHT_RESET = 480;

  // payload widths
  localparam int PIX_W   = 8;
  localparam int MAG_W   = 8;
  localparam int COORD_W = 11;
  localparam int LINE_W  = 2 * PIX_W;

  // gray conversion: sum / 3 as (sum * 683) >> 11, exact for sums up to 765
  localparam int GRAY_SUM_W  = 10;
  localparam int GRAY_PROD_W = 20;
  localparam int GRAY_RECIP  = 683;
  localparam int GRAY_SHIFT  = 11;

  // gradient path
  localparam int GRAD_W    = 13;
  localparam int SQ_W      = 24;
  localparam int RAD_W     = 25;
  localparam int ROOT_W    = 13;
  localparam int MAG_SHIFT = 3;
  localparam int MAG_MAX   = 255;
  localparam logic signed [GRAD_W-1:0] KERN_SMALL = GRAD_W'(3);
  localparam logic signed [GRAD_W-1:0] KERN_LARGE = GRAD_W'(10);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_MULT,
    S_ADD,
    S_SQRT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic calc;
    logic mult;
    logic start_sqrt;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic interior;
    logic sqrt_done;
    logic out_free;
  } ctrl_status_t;

  function automatic logic signed [GRAD_W-1:0] gray_ext(input logic [PIX_W-1:0] v);
    return $signed({{(GRAD_W-PIX_W){1'b0}}, v});
  endfunction

endpackage

[design/sem_pixel_if.sv]
// ----------------------------------------------------------------------------
// sem_pixel_if
// Pixel stream channel: valid/ready handshake with one rgb pixel per transfer.
// ----------------------------------------------------------------------------
interface sem_pixel_if import sem_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blue;
  logic [PIX_W-1:0] green;
  logic [PIX_W-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink (input valid, blue, green, red, output ready);
endinterface

[design/sem_result_if.sv]
// ----------------------------------------------------------------------------
// sem_result_if
// Result stream channel: valid/ready handshake with one edge sample per transfer.
// ----------------------------------------------------------------------------
interface sem_result_if import sem_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MAG_W-1:0]   magnitude;
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic               last_of_frame;

  modport source (output valid, magnitude, column, row, last_of_frame, input ready);
  modport sink (input valid, magnitude, column, row, last_of_frame, output ready);
endinterface

[design/sem_ram.sv]
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sem_isqrt.sv]
// ----------------------------------------------------------------------------
// sem_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sem_isqrt import sem_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int START_POS = ((RAD_W - 1) / 2) * 2;

  logic             active;
  logic [RAD_W-1:0] v;
  logic [RAD_W-1:0] res;
  logic [RAD_W-1:0] bitv;
  logic [RAD_W:0]   trial;

  assign trial = {1'b0, res} + {1'b0, bitv};
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= active && bitv[0];
      if (start) begin
        active <= 1'b1;
      end else if (active && bitv[0]) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= radicand;
      res  <= '0;
      bitv <= RAD_W'(1) << START_POS;
    end else if (active) begin
      if ({1'b0, v} >= trial) begin
        v   <= v - trial[RAD_W-1:0];
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

[design/sem_datapath.sv]
// ----------------------------------------------------------------------------
// sem_datapath
// Gray conversion, line store, 3x3 window, scharr gradients, magnitude and
// the output register.
// ----------------------------------------------------------------------------
module sem_datapath import sem_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  input  ctrl_cmd_t              cmd,
  output ctrl_status_t           status,
  sem_pixel_if.sink              pixel,
  sem_result_if.source           result
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int EWW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int EHW = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  logic [CFG_W-1:0] width_cfg;
  logic [CFG_W-1:0] height_cfg;
  logic [EWW-1:0]   width_ext;
  logic [EHW-1:0]   height_ext;
  logic [CW:0]      eff_width;
  logic [RW:0]      eff_height;
  logic             cfg_hit;

  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW:0]   col_plus;
  logic [RW:0]   row_plus;
  logic          col_wrap;
  logic          row_wrap;

  logic                   accept;
  logic [GRAY_SUM_W-1:0]  gray_sum;
  logic [GRAY_PROD_W-1:0] gray_prod;
  logic [PIX_W-1:0]       gray;

  logic [LINE_W-1:0] line_rd;
  logic [PIX_W-1:0]  line_prev;
  logic [PIX_W-1:0]  line_prev2;
  logic [PIX_W-1:0]  win [6];

  logic signed [GRAD_W-1:0]   gx_calc;
  logic signed [GRAD_W-1:0]   gy_calc;
  logic signed [GRAD_W-1:0]   gx;
  logic signed [GRAD_W-1:0]   gy;
  logic signed [2*GRAD_W-1:0] gx_sq_full;
  logic signed [2*GRAD_W-1:0] gy_sq_full;
  logic [SQ_W-1:0]            gx_sq;
  logic [SQ_W-1:0]            gy_sq;
  logic [RAD_W-1:0]           radicand;

  logic [COORD_W-1:0]      center_col;
  logic [COORD_W-1:0]      center_row;
  logic                    center_last;
  logic                    sqrt_done;
  logic [ROOT_W-1:0]       root;
  logic [ROOT_W-MAG_SHIFT-1:0] mag_raw;
  logic [MAG_W-1:0]        mag_clamped;
  logic                    out_valid;

  // configuration
  assign cfg_hit = cfg_write &&
                   (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= CFG_W'(IMAGE_WIDTH_RESET);
      height_cfg <= CFG_W'(IMAGE_HEIGHT_RESET);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_cfg  <= cfg_data;
        REG_IMAGE_HEIGHT: height_cfg <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_ext  = EWW'(width_cfg);
  assign height_ext = EHW'(height_cfg);

  always_comb begin
    if (width_cfg == '0) begin
      eff_width = (CW + 1)'(1);
    end else if (width_ext > EWW'(MAX_WIDTH)) begin
      eff_width = (CW + 1)'(MAX_WIDTH);
    end else begin
      eff_width = width_ext[CW:0];
    end
    if (height_cfg == '0) begin
      eff_height = (RW + 1)'(1);
    end else if (height_ext > EHW'(MAX_HEIGHT)) begin
      eff_height = (RW + 1)'(MAX_HEIGHT);
    end else begin
      eff_height = height_ext[RW:0];
    end
  end

  // position counters
  assign col_plus = {1'b0, col_count} + (CW + 1)'(1);
  assign row_plus = {1'b0, row_count} + (RW + 1)'(1);
  assign col_wrap = col_plus >= eff_width;
  assign row_wrap = row_plus >= eff_height;

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
    end else if (cmd.calc) begin
      if (col_wrap) begin
        col_count <= '0;
        row_count <= row_wrap ? '0 : row_plus[RW-1:0];
      end else begin
        col_count <= col_plus[CW-1:0];
      end
    end
  end

  // gray conversion on transfer
  assign accept      = pixel.valid && cmd.in_ready;
  assign pixel.ready = cmd.in_ready;
  assign gray_sum    = GRAY_SUM_W'(pixel.blue) + GRAY_SUM_W'(pixel.green)
                     + GRAY_SUM_W'(pixel.red);
  assign gray_prod   = GRAY_PROD_W'(gray_sum) * GRAY_PROD_W'(GRAY_RECIP);

  always_ff @(posedge clk) begin
    if (accept) begin
      gray <= gray_prod[GRAY_SHIFT +: PIX_W];
    end
  end

  // line store: upper byte two rows above, lower byte one row above
  sem_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (cmd.calc),
    .waddr (col_count),
    .wdata ({line_prev, gray}),
    .raddr (col_count),
    .rdata (line_rd)
  );

  assign line_prev2 = line_rd[LINE_W-1:PIX_W];
  assign line_prev  = line_rd[PIX_W-1:0];

  // window: 0..2 left column, 3..5 center column, top to bottom
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (cmd.calc) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= line_prev2;
      win[4] <= line_prev;
      win[5] <= gray;
    end
  end

  assign gx_calc = KERN_SMALL * (gray_ext(line_prev2) - gray_ext(win[0]))
                 + KERN_LARGE * (gray_ext(line_prev) - gray_ext(win[1]))
                 + KERN_SMALL * (gray_ext(gray) - gray_ext(win[2]));
  assign gy_calc = KERN_SMALL * (gray_ext(win[2]) - gray_ext(win[0]))
                 + KERN_LARGE * (gray_ext(win[5]) - gray_ext(win[3]))
                 + KERN_SMALL * (gray_ext(gray) - gray_ext(line_prev2));

  assign status.interior = (col_count >= CW'(2)) && (row_count >= RW'(2));

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      gx          <= gx_calc;
      gy          <= gy_calc;
      center_col  <= COORD_W'(col_count - 1'b1);
      center_row  <= COORD_W'(row_count - 1'b1);
      center_last <= col_wrap && row_wrap;
    end
  end

  // squares, then sum into the root unit
  assign gx_sq_full = gx * gx;
  assign gy_sq_full = gy * gy;

  always_ff @(posedge clk) begin
    if (cmd.mult) begin
      gx_sq <= gx_sq_full[SQ_W-1:0];
      gy_sq <= gy_sq_full[SQ_W-1:0];
    end
  end

  assign radicand = {1'b0, gx_sq} + {1'b0, gy_sq};

  sem_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start_sqrt),
    .radicand (radicand),
    .done     (sqrt_done),
    .root     (root)
  );

  assign mag_raw     = root[ROOT_W-1:MAG_SHIFT];
  assign mag_clamped = (mag_raw > (ROOT_W - MAG_SHIFT)'(MAG_MAX)) ? MAG_W'(MAG_MAX)
                                                                  : mag_raw[MAG_W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.magnitude     <= mag_clamped;
      result.column        <= center_col;
      result.row           <= center_row;
      result.last_of_frame <= center_last;
    end
  end

  assign result.valid     = out_valid;
  assign status.in_valid  = pixel.valid;
  assign status.sqrt_done = sqrt_done;
  assign status.out_free  = !out_valid || result.ready;

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> col_count == '0 && row_count == '0)
    else $error("frame position not cleared after register write");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> result.valid)
    else $error("loaded result not presented");

  a_calc_after_transfer: assert property (@(posedge clk) disable iff (rst)
    cmd.calc |-> $past(pixel.valid && pixel.ready))
    else $error("window step without a pixel transfer");

endmodule

[design/sem_ctrl.sv]
// ----------------------------------------------------------------------------
// sem_ctrl
// Sequencer: pixel transfer, window step, squares, root and result load.
// ----------------------------------------------------------------------------
module sem_ctrl import sem_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (status.in_valid) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = status.interior ? S_MULT : S_IDLE;
      end
      S_MULT: begin
        cmd.mult   = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.start_sqrt = 1'b1;
        state_next     = S_SQRT;
      end
      S_SQRT: begin
        if (status.sqrt_done) begin
          if (status.out_free) begin
            cmd.load_out = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_calc_from_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |-> $past(state) == S_IDLE && $past(status.in_valid))
    else $error("window step entered without a transfer");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result register overwritten while occupied");

  a_root_after_squares: assert property (@(posedge clk) disable iff (rst)
    cmd.start_sqrt |-> $past(cmd.mult))
    else $error("root started without fresh squares");

endmodule

[design/scharr_edge_magnitude_top.sv]
// A pixel transfer passes the window step and, inside the frame interior, the squares,
// the bit-serial square root and the result load; the next pixel is taken only after that,
// and on the border right after the window step.
// The result register lets the next pixel in while a result waits to be taken.
// Reset (rst, synchronous): width 640, height 480, frame position and window cleared;
// the line store is not cleared.
// ----------------------------------------------------------------------------
// scharr_edge_magnitude_top
// Streaming scharr 3x3 edge magnitude over rgb pixels in raster order.
// ----------------------------------------------------------------------------
module scharr_edge_magnitude_top import sem_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data,
  sem_pixel_if.sink              pixel,
  sem_result_if.source           result
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  sem_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  sem_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .pixel     (pixel),
    .result    (result)
  );

endmodule

[bench/tb_scharr_edge_magnitude_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_scharr_edge_magnitude_top
// Streams rgb frames of many sizes through the scharr edge magnitude block and
// compares every edge result, field by field, with a predictor kept in step
// with the accepted pixels. Covers pixel extremes, register limits, frame
// restart on register writes, long output stalls and random frames.
// ----------------------------------------------------------------------------
module tb_scharr_edge_magnitude_top;
  import sem_pkg::*;

  localparam int SETTLE_CYCLES     = 40;
  localparam int CYCLE_LIMIT       = 2_000_000;
  localparam int RANDOM_PIXELS     = 450;
  localparam int LIMIT_ROWS        = 40;
  localparam int ERROR_PRINT_LIMIT = 50;
  localparam int LONG_HOLD_CYCLES  = 300;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_HIGH = CFG_INDEX_W'(15);

  typedef struct packed {
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [MAG_W-1:0]   magnitude;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               last_of_frame;
  } edge_sample_t;

  typedef enum {FILL_UNIFORM, FILL_BILEVEL} fill_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0]       cfg_data;

  sem_pixel_if  pix_ch ();
  sem_result_if res_ch ();

  scharr_edge_magnitude_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pixel(pix_ch),
    .result(res_ch)
  );

  // predictor state
  int unsigned  frame_width  = IMAGE_WIDTH_RESET;
  int unsigned  frame_height = IMAGE_HEIGHT_RESET;
  int unsigned  pos_col = 0;
  int unsigned  pos_row = 0;
  byte unsigned gray_row_above [MAX_WIDTH_DEF];
  byte unsigned gray_row_two_above [MAX_WIDTH_DEF];
  byte unsigned gray_window [6];

  edge_sample_t pending_edges [$];

  bit steady = 1'b0;
  int hold_request = 0;
  int mismatches = 0;
  int pixels_sent = 0;
  int edges_checked = 0;
  int reg_writes = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned max_v);
    if (v == 0) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  function automatic bit predict_edge(input pixel_t px, output edge_sample_t e);
    int unsigned w, h, idx, gray, sum_sq, root, trial, mag;
    int top0, top1, top2, mid0, mid2, bot0, bot1, bot2, gx, gy, b;
    bit interior;
    w = clamp_size(frame_width, MAX_WIDTH_DEF);
    h = clamp_size(frame_height, MAX_HEIGHT_DEF);
    idx = (pos_col < MAX_WIDTH_DEF) ? pos_col : MAX_WIDTH_DEF - 1;
    gray = (int'(px.blue) + int'(px.green) + int'(px.red)) / 3;
    top0 = gray_window[0];
    mid0 = gray_window[1];
    bot0 = gray_window[2];
    top1 = gray_window[3];
    bot1 = gray_window[5];
    top2 = gray_row_two_above[idx];
    mid2 = gray_row_above[idx];
    bot2 = gray;
    interior = pos_col >= 2 && pos_col < w && pos_row >= 2 && pos_row < h;
    if (interior) begin
      gx = 3 * (top2 - top0) + 10 * (mid2 - mid0) + 3 * (bot2 - bot0);
      gy = 3 * (bot0 - top0) + 10 * (bot1 - top1) + 3 * (bot2 - top2);
      sum_sq = gx * gx + gy * gy;
      root = 0;
      for (b = 12; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= sum_sq) root = trial;
      end
      mag = root / 8;
      if (mag > MAG_MAX) mag = MAG_MAX;
      e.magnitude     = MAG_W'(mag);
      e.column        = COORD_W'(pos_col - 1);
      e.row           = COORD_W'(pos_row - 1);
      e.last_of_frame = (pos_col + 1 == w) && (pos_row + 1 == h);
    end
    gray_window[0] = gray_window[3];
    gray_window[1] = gray_window[4];
    gray_window[2] = gray_window[5];
    gray_window[3] = top2;
    gray_window[4] = mid2;
    gray_window[5] = gray;
    gray_row_two_above[idx] = mid2;
    gray_row_above[idx] = gray;
    if (pos_col + 1 >= w) begin
      pos_col = 0;
      pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
    return interior;
  endfunction

  function automatic void compare_field(input string field, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      if (mismatches < ERROR_PRINT_LIMIT)
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  function automatic pixel_t random_pixel(input fill_t fill);
    pixel_t px;
    if (fill == FILL_BILEVEL) begin
      px.blue  = $urandom_range(0, 1) ? '1 : '0;
      px.green = $urandom_range(0, 1) ? '1 : '0;
      px.red   = $urandom_range(0, 1) ? '1 : '0;
    end else begin
      px = pixel_t'($urandom);
    end
    return px;
  endfunction

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid && hold_request == 0) @(posedge clk);
      if (res_ch.valid) begin
        if (pending_edges.size() == 0) begin
          if (mismatches < ERROR_PRINT_LIMIT)
            $error("unexpected result transfer: magnitude %0d column %0d row %0d",
                   res_ch.magnitude, res_ch.column, res_ch.row);
          mismatches++;
        end else begin
          edge_sample_t want;
          want = pending_edges.pop_front();
          compare_field("magnitude", want.magnitude, res_ch.magnitude);
          compare_field("column", want.column, res_ch.column);
          compare_field("row", want.row, res_ch.row);
          compare_field("last_of_frame", want.last_of_frame, res_ch.last_of_frame);
          edges_checked++;
        end
      end
    end
  end

  task automatic send_pixel(input pixel_t px);
    edge_sample_t predicted;
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.blue  <= px.blue;
    pix_ch.green <= px.green;
    pix_ch.red   <= px.red;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    pixels_sent++;
    if (predict_edge(px, predicted)) pending_edges.push_back(predicted);
  endtask

  task automatic send_pixels(input int count, input fill_t fill);
    repeat (count) send_pixel(random_pixel(fill));
  endtask

  // stop offering pixels and let the block drain completely
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= CFG_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
    if (index == REG_IMAGE_WIDTH) begin
      frame_width = value & 12'hFFF;
      pos_col = 0;
      pos_row = 0;
    end else if (index == REG_IMAGE_HEIGHT) begin
      frame_height = value & 12'hFFF;
      pos_col = 0;
      pos_row = 0;
    end
  endtask

  task automatic test_pixel_extremes();
    logic [3*PIX_W-1:0] mixed [9] = '{24'h000000, 24'hFFFFFF, 24'h010100,
                                      24'h020201, 24'hFF0000, 24'h00FF00,
                                      24'h0000FF, 24'h804020, 24'hFEFEFE};
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, 3);
    // vertical edge, black to white: saturates the magnitude
    for (int i = 0; i < 9; i++)
      send_pixel((i % 3 == 2) ? pixel_t'('1) : pixel_t'('0));
    for (int i = 0; i < 9; i++)
      send_pixel(pixel_t'(mixed[i]));
    // horizontal edge, white over black: negative gradient
    for (int i = 0; i < 9; i++)
      send_pixel((i < 3) ? pixel_t'('1) : pixel_t'('0));
  endtask

  task automatic test_register_limits();
    write_reg(REG_IMAGE_WIDTH, 0);
    write_reg(REG_IMAGE_HEIGHT, 0);
    send_pixels(3, FILL_UNIFORM);
    write_reg(REG_IMAGE_WIDTH, 2);
    write_reg(REG_IMAGE_HEIGHT, 5);
    send_pixels(12, FILL_UNIFORM);
    write_reg(REG_IMAGE_WIDTH, 6);
    write_reg(REG_IMAGE_HEIGHT, 2);
    send_pixels(14, FILL_BILEVEL);
    write_reg(REG_IMAGE_WIDTH, 12'hFFF);
    write_reg(REG_IMAGE_HEIGHT, 3);
    send_pixels(LIMIT_ROWS, FILL_UNIFORM);
    write_reg(REG_IMAGE_WIDTH, 3);
    write_reg(REG_IMAGE_HEIGHT, MAX_HEIGHT_DEF);
    send_pixels(3 * LIMIT_ROWS, FILL_BILEVEL);
  endtask

  task automatic test_frame_restart();
    write_reg(REG_IMAGE_WIDTH, 6);
    write_reg(REG_IMAGE_HEIGHT, 5);
    send_pixels(20, FILL_UNIFORM);
    // writes to unused indexes leave the frame position alone
    write_reg(REG_UNUSED_LOW, 5);
    write_reg(REG_UNUSED_HIGH, 12'hFFF);
    send_pixels(10, FILL_UNIFORM);
    send_pixels(17, FILL_BILEVEL);
    write_reg(REG_IMAGE_WIDTH, 6);
    send_pixels(30, FILL_UNIFORM);
  endtask

  task automatic test_backpressure();
    write_reg(REG_IMAGE_WIDTH, 8);
    write_reg(REG_IMAGE_HEIGHT, 6);
    hold_request = LONG_HOLD_CYCLES;
    send_pixels(48, FILL_BILEVEL);
    steady = 1'b1;
    send_pixels(48, FILL_UNIFORM);
    steady = 1'b0;
    send_pixels(20, FILL_UNIFORM);
    settle();
    send_pixels(28, FILL_UNIFORM);
  endtask

  task automatic test_random_frames();
    int start, w, h, area, n;
    fill_t fill;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: begin
          w = $urandom_range(0, 2);
          h = $urandom_range(0, 4);
        end
        1: begin
          w = $urandom_range(17, 40);
          h = 3;
        end
        default: begin
          w = $urandom_range(3, 12);
          h = $urandom_range(3, 8);
        end
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
      end else begin
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_IMAGE_WIDTH, w);
      end
      area = clamp_size(w, MAX_WIDTH_DEF) * clamp_size(h, MAX_HEIGHT_DEF);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, area)
                                      : area * $urandom_range(1, 3);
      fill = $urandom_range(0, 2) == 0 ? FILL_BILEVEL : FILL_UNIFORM;
      steady = $urandom_range(0, 3) == 0;
      send_pixels(n, fill);
    end
    steady = 1'b0;
  endtask

  initial begin
    pix_ch.valid <= 1'b0;
    pix_ch.blue  <= '0;
    pix_ch.green <= '0;
    pix_ch.red   <= '0;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_pixel_extremes();
    test_register_limits();
    test_frame_restart();
    test_backpressure();
    test_random_frames();
    settle();

    $display("covered %0d pixel transfers and %0d register writes, %0d edge results compared",
             pixels_sent, reg_writes, edges_checked);
    $display("frame sizes from 1x1 to the register limits, restarts and long output stalls");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
